[hdl/fsk_receive_sequencer_macros.svh]
// Assertion helpers for the FSK receive sequencer.
// Each macro expects clk and rst_n in scope.
`ifndef FSK_RECEIVE_SEQUENCER_MACROS_SVH
`define FSK_RECEIVE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FSKRS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsk_receive_sequencer: check failed");

// Next-cycle implication, disabled during reset.
`define FSKRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsk_receive_sequencer: check failed");

`endif

[hdl/fskrs_pkg.sv]
package fskrs_pkg;

  // Status codes reported on the result word
  typedef enum logic [2:0] {
    ST_START   = 3'd0,
    ST_WAIT    = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_DATA    = 3'd3,
    ST_IDLE    = 3'd4,
    ST_ERROR   = 3'd5
  } status_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MARK_RUN   = 2'd0;
  localparam cfg_idx_t CFG_FLAG_THR   = 2'd1;
  localparam cfg_idx_t CFG_SNR_THR    = 2'd2;
  localparam cfg_idx_t CFG_WAIT_BLKS  = 2'd3;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned BITS_W      = 9;

  // Register reset values
  localparam logic [5:0]  MARK_RUN_RST  = 6'd6;
  localparam logic [7:0]  FLAG_THR_RST  = 8'd4;
  localparam logic signed [15:0] SNR_THR_RST = 16'sd5;
  localparam logic [15:0] WAIT_BLKS_RST = 16'd1;

endpackage

[hdl/fsk_receive_sequencer.sv]
// Pipeline: an accepted word is held in the input register; a block-end word then
//   loads the result register, which drives the out_ ports, once the slot is free.
// Throughput: one input word per cycle unless a block-end word waits on a stalled
//   result slot, set by the single update of the counters and phase between the input register and the result register.
// Reset: synchronous active-low rst_n clears the pipeline, phase, counters, flags
//   and restores the configuration registers to their defaults.
module fsk_receive_sequencer #(
  parameter int unsigned MAX_BLOCK_BITS = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  fskrs_pkg::cfg_idx_t                cfg_index,
  input  logic [fskrs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_unit_bit,
  input  logic                               in_has_unit,
  input  logic                               in_last_in_block,
  input  logic                               in_carrier_present,
  input  logic signed [15:0]                 in_snr_estimate,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         out_status_code,
  output logic                               out_carrier_flag,
  output logic                               out_data_flag,
  output logic                               out_error_flag,
  output logic                               out_low_snr_flag,
  output logic                               out_idle_flag,
  output logic [8:0]                         out_bits_reported
);

  import fskrs_pkg::*;

  localparam int unsigned BIT_LIMIT_I = (MAX_BLOCK_BITS < 511) ? MAX_BLOCK_BITS : 511;
  localparam logic [BITS_W-1:0] BIT_LIMIT = BIT_LIMIT_I[BITS_W-1:0];
  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    PH_START,
    PH_WAIT,
    PH_DATA,
    PH_IDLE,
    PH_ERROR
  } phase_t;

  // Configuration registers
  logic [5:0]         mark_run_r;
  logic [7:0]         flag_thr_r;
  logic signed [15:0] snr_thr_r;
  logic [15:0]        wait_blks_r;

  // Input register
  logic               s1_valid_r;
  logic               s1_bit_r;
  logic               s1_has_r;
  logic               s1_last_r;
  logic               s1_carrier_r;
  logic signed [15:0] s1_snr_r;

  // Sequencer state
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   ones_run_r, ones_run_nxt;
  logic [CNT_W-1:0]   flag_cnt_r, flag_cnt_nxt;
  logic [CNT_W-1:0]   hold_r, hold_nxt;
  logic [BITS_W-1:0]  bbc_r, bbc_nxt;
  status_t            status_r, status_nxt;
  logic               fb_carrier_r, fb_carrier_nxt;
  logic               fb_data_r, fb_data_nxt;
  logic               fb_error_r, fb_error_nxt;
  logic               fb_lowsnr_r, fb_lowsnr_nxt;
  logic               fb_idle_r, fb_idle_nxt;
  logic [BITS_W-1:0]  bits_nxt;

  // Result register
  logic               out_valid_r;
  status_t            out_status_r;
  logic               out_carrier_r;
  logic               out_data_r;
  logic               out_error_r;
  logic               out_lowsnr_r;
  logic               out_idle_r;
  logic [BITS_W-1:0]  out_bits_r;

  logic               out_free;
  logic               proc;
  logic [BITS_W-1:0]  bbc_inc;

  // A word without block end needs no result slot
  assign out_free = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !proc;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_run_r  <= MARK_RUN_RST;
      flag_thr_r  <= FLAG_THR_RST;
      snr_thr_r   <= SNR_THR_RST;
      wait_blks_r <= WAIT_BLKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MARK_RUN:  mark_run_r  <= cfg_wdata[5:0];
        CFG_FLAG_THR:  flag_thr_r  <= cfg_wdata[7:0];
        CFG_SNR_THR:   snr_thr_r   <= cfg_wdata;
        CFG_WAIT_BLKS: wait_blks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_bit_r     <= in_unit_bit;
      s1_has_r     <= in_has_unit;
      s1_last_r    <= in_last_in_block;
      s1_carrier_r <= in_carrier_present;
      s1_snr_r     <= in_snr_estimate;
    end
  end

  // Per-word update: bit counting, flag search, block close
  always_comb begin
    phase_nxt      = phase_r;
    ones_run_nxt   = ones_run_r;
    flag_cnt_nxt   = flag_cnt_r;
    hold_nxt       = hold_r;
    status_nxt     = status_r;
    fb_carrier_nxt = fb_carrier_r;
    fb_data_nxt    = fb_data_r;
    fb_error_nxt   = fb_error_r;
    fb_lowsnr_nxt  = fb_lowsnr_r;
    fb_idle_nxt    = fb_idle_r;
    bits_nxt       = '0;
    bbc_inc        = bbc_r;

    if (s1_has_r) begin
      if (bbc_r < BIT_LIMIT) bbc_inc = bbc_r + 1'b1;
      // flag = exact run of marks closed by a space
      if (phase_r == PH_START) begin
        if (ones_run_r == {{(CNT_W-6){1'b0}}, mark_run_r} && !s1_bit_r &&
            flag_cnt_r != CNT_MAX) begin
          flag_cnt_nxt = flag_cnt_r + 1'b1;
        end
        if (s1_bit_r) begin
          if (ones_run_r != CNT_MAX) ones_run_nxt = ones_run_r + 1'b1;
        end else begin
          ones_run_nxt = '0;
        end
      end
    end
    bbc_nxt = bbc_inc;

    if (s1_last_r) begin
      bbc_nxt      = '0;
      fb_error_nxt = 1'b0;
      unique case (phase_r)
        PH_START: begin
          status_nxt     = ST_START;
          fb_carrier_nxt = 1'b0;
          if (s1_carrier_r && (flag_cnt_nxt > {{(CNT_W-8){1'b0}}, flag_thr_r})) begin
            fb_carrier_nxt = 1'b1;
            hold_nxt       = wait_blks_r;
            phase_nxt      = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (!s1_carrier_r) begin
            phase_nxt      = PH_ERROR;
            status_nxt     = ST_ERROR;
            fb_error_nxt   = 1'b1;
            fb_carrier_nxt = 1'b0;
          end else if (hold_r > 16'd1) begin
            fb_carrier_nxt = 1'b1;
            status_nxt     = ST_WAIT;
            hold_nxt       = hold_r - 1'b1;
          end else begin
            // hold expired: first data block reports as timeout
            fb_carrier_nxt = 1'b1;
            hold_nxt       = '0;
            status_nxt     = ST_TIMEOUT;
            phase_nxt      = PH_DATA;
            fb_data_nxt    = 1'b1;
            bits_nxt       = bbc_inc;
          end
        end
        PH_DATA: begin
          if (s1_carrier_r) begin
            status_nxt     = ST_DATA;
            fb_carrier_nxt = 1'b1;
            fb_lowsnr_nxt  = (s1_snr_r <= snr_thr_r);
            bits_nxt       = bbc_inc;
          end else begin
            // carrier lost: this block already counts as idle
            phase_nxt      = PH_IDLE;
            hold_nxt       = '0;
            fb_idle_nxt    = 1'b1;
            fb_data_nxt    = 1'b0;
            fb_carrier_nxt = 1'b0;
            status_nxt     = ST_IDLE;
          end
        end
        PH_IDLE: begin
          status_nxt     = ST_IDLE;
          fb_carrier_nxt = s1_carrier_r;
        end
        PH_ERROR: begin
          // status stays at error from the wait exit
          fb_error_nxt = 1'b1;
        end
        default: begin
          phase_nxt    = PH_ERROR;
          fb_error_nxt = 1'b1;
        end
      endcase
    end
  end

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      ones_run_r   <= '0;
      flag_cnt_r   <= '0;
      hold_r       <= '0;
      bbc_r        <= '0;
      status_r     <= ST_START;
      fb_carrier_r <= 1'b0;
      fb_data_r    <= 1'b0;
      fb_error_r   <= 1'b0;
      fb_lowsnr_r  <= 1'b0;
      fb_idle_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (proc) begin
        phase_r      <= phase_nxt;
        ones_run_r   <= ones_run_nxt;
        flag_cnt_r   <= flag_cnt_nxt;
        hold_r       <= hold_nxt;
        bbc_r        <= bbc_nxt;
        status_r     <= status_nxt;
        fb_carrier_r <= fb_carrier_nxt;
        fb_data_r    <= fb_data_nxt;
        fb_error_r   <= fb_error_nxt;
        fb_lowsnr_r  <= fb_lowsnr_nxt;
        fb_idle_r    <= fb_idle_nxt;
      end
      if (proc && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded only when the slot is free
  always_ff @(posedge clk) begin
    if (proc && s1_last_r) begin
      out_status_r  <= status_nxt;
      out_carrier_r <= fb_carrier_nxt;
      out_data_r    <= fb_data_nxt;
      out_error_r   <= fb_error_nxt;
      out_lowsnr_r  <= fb_lowsnr_nxt;
      out_idle_r    <= fb_idle_nxt;
      out_bits_r    <= bits_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status_code   = out_status_r;
  assign out_carrier_flag  = out_carrier_r;
  assign out_data_flag     = out_data_r;
  assign out_error_flag    = out_error_r;
  assign out_low_snr_flag  = out_lowsnr_r;
  assign out_idle_flag     = out_idle_r;
  assign out_bits_reported = out_bits_r;

endmodule

[hdl/fskrs_checker.sv]
`include "fsk_receive_sequencer_macros.svh"

module fskrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status_code,
  input logic        out_carrier_flag,
  input logic        out_data_flag,
  input logic        out_error_flag,
  input logic        out_idle_flag,
  input logic [8:0]  out_bits_reported
);

  import fskrs_pkg::*;

  // a stalled result word holds
  `FSKRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status_code) && $stable(out_bits_reported))

  // the timeout block opens the data phase with carrier up
  `FSKRS_ASSERT_IMPLY(a_timeout_flags, out_valid && out_status_code == ST_TIMEOUT, out_data_flag && out_carrier_flag)

  // bits are delivered only in data or timeout blocks
  `FSKRS_ASSERT_IMPLY(a_bits_zero, out_valid && out_status_code != ST_DATA && out_status_code != ST_TIMEOUT, out_bits_reported == 9'd0)

  // an error event is only reported with error status
  `FSKRS_ASSERT_IMPLY(a_error_status, out_valid && out_error_flag, out_status_code == ST_ERROR && !out_carrier_flag)

  // idle is terminal and excludes the data phase
  `FSKRS_ASSERT_IMPLY(a_idle_status, out_valid && out_idle_flag, out_status_code == ST_IDLE && !out_data_flag)

endmodule

bind fsk_receive_sequencer fskrs_checker u_fskrs_checker (.*);
